### rtl/core/rta_pkg.sv
// shared constants, types and helpers for the rectangle tween animator
`default_nettype none

package rta_pkg;

    localparam int COORD_BITS    = 8;
    localparam int OUT_BITS      = COORD_BITS + 1;
    localparam int NUM_AXES      = 4;
    localparam int AXIS_IDX_W    = 2;
    localparam int RECT_W        = NUM_AXES * COORD_BITS;
    localparam int DUR_W         = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OUT_BITS-1:0]   out_coord_t;

    // axis start value that marks a relative axis
    localparam coord_t REL_MARK = '1;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_RESTART = 2'd1,
        MODE_RELOAD  = 2'd2,
        MODE_STOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_START_RECT  = 2'd0,
        REG_TARGET_RECT = 2'd1,
        REG_DURATION    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                  latch_item;
        logic                  apply_mode;
        logic                  div_start;
        logic                  axis_wr;
        logic [AXIS_IDX_W-1:0] axis;
        logic                  out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
        logic is_restart;
    } dp_status_t;

    function automatic coord_t rect_field(input logic [RECT_W-1:0] r,
                                          input logic [AXIS_IDX_W-1:0] a);
        return r[a*COORD_BITS +: COORD_BITS];
    endfunction

endpackage

`default_nettype wire

### rtl/core/rta_item_if.sv
// input item channel
`default_nettype none

interface rta_item_if import rta_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    coord_t     original_col;
    coord_t     original_row;
    coord_t     original_width;
    coord_t     original_height;

    modport source (
        output valid, mode, original_col, original_row, original_width, original_height,
        input  ready
    );
    modport sink (
        input  valid, mode, original_col, original_row, original_width, original_height,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/rta_result_if.sv
// result item channel
`default_nettype none

interface rta_result_if import rta_pkg::*; ();
    logic       valid;
    logic       ready;
    out_coord_t rect_col;
    out_coord_t rect_row;
    out_coord_t rect_width;
    out_coord_t rect_height;
    logic       finished;

    modport source (
        output valid, rect_col, rect_row, rect_width, rect_height, finished,
        input  ready
    );
    modport sink (
        input  valid, rect_col, rect_row, rect_width, rect_height, finished,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/rta_regs.sv
// apb configuration registers
`default_nettype none

module rta_regs import rta_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [RECT_W-1:0] start_rect,
    output logic [RECT_W-1:0] target_rect,
    output logic [DUR_W-1:0]  duration
);

    logic [RECT_W-1:0] start_rect_reg;
    logic [RECT_W-1:0] target_rect_reg;
    logic [DUR_W-1:0]  duration_reg;
    logic [1:0]        idx;
    logic              wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rect_reg  <= '0;
            target_rect_reg <= '0;
            duration_reg    <= DUR_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START_RECT:  start_rect_reg  <= pwdata[RECT_W-1:0];
                REG_TARGET_RECT: target_rect_reg <= pwdata[RECT_W-1:0];
                REG_DURATION:    duration_reg    <= pwdata[DUR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_RECT:  prdata = DATA_W'(start_rect_reg);
            REG_TARGET_RECT: prdata = DATA_W'(target_rect_reg);
            REG_DURATION:    prdata = DATA_W'(duration_reg);
            default:         prdata = '0;
        endcase
    end

    assign start_rect  = start_rect_reg;
    assign target_rect = target_rect_reg;
    assign duration    = duration_reg;

endmodule

`default_nettype wire

### rtl/core/rta_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rta_div import rta_pkg::*; #(
    parameter int W = TIME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    always_comb
    begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = diff[W] ? shifted : diff;
            quo_next  = {quo_reg[W-2:0], ~diff[W]};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/rta_datapath.sv
// axis state, step derivation, tick, reload and stop update and result register
`default_nettype none

module rta_datapath import rta_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [1:0]        mode,
    input  coord_t            original_col,
    input  coord_t            original_row,
    input  coord_t            original_width,
    input  coord_t            original_height,
    input  logic [RECT_W-1:0] start_rect,
    input  logic [RECT_W-1:0] target_rect,
    input  logic [DUR_W-1:0]  duration,
    input  logic              out_ready,
    output logic              out_valid,
    output out_coord_t        rect_col,
    output out_coord_t        rect_row,
    output out_coord_t        rect_width,
    output out_coord_t        rect_height,
    output logic              finished
);

    localparam int DIV_W = (TIME_BITS > COORD_BITS) ? TIME_BITS : COORD_BITS;
    localparam int EXT_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

    logic [1:0]           mode_reg;
    coord_t               orig_reg  [NUM_AXES];
    coord_t               pos_reg   [NUM_AXES];
    coord_t               pos_next  [NUM_AXES];
    coord_t               step_reg  [NUM_AXES];
    coord_t               step_next [NUM_AXES];
    logic [TIME_BITS-1:0] hp_reg    [NUM_AXES];
    logic [TIME_BITS-1:0] hp_next   [NUM_AXES];
    logic [TIME_BITS-1:0] hc_reg    [NUM_AXES];
    logic [TIME_BITS-1:0] hc_next   [NUM_AXES];
    logic [NUM_AXES-1:0]  every_reg, every_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 done_reg, done_next;
    out_coord_t           out_reg   [NUM_AXES];
    logic                 fin_reg;
    logic                 out_valid_reg;

    // per-axis derivation inputs
    logic [EXT_W-1:0]     dur_ext;
    logic [TIME_BITS-1:0] t_val;
    coord_t               s_f, g_f;
    logic                 rel;
    logic signed [COORD_BITS:0] s_x, g_x, rng, neg_rng;
    logic [COORD_BITS-1:0] mag;
    logic                 neg, zero, big;
    logic [DIV_W-1:0]     mag_x, t_x, t_div, dividend, divisor, quo;
    logic                 div_busy;
    coord_t               q8, wr_step;

    assign dur_ext = EXT_W'(duration);
    assign t_val   = dur_ext[TIME_BITS-1:0];

    always_comb
    begin
        s_f     = rect_field(start_rect, cmd.axis);
        g_f     = rect_field(target_rect, cmd.axis);
        rel     = (s_f == REL_MARK);
        s_x     = (COORD_BITS+1)'(s_f);
        g_x     = (COORD_BITS+1)'(g_f);
        rng     = rel ? g_x : g_x - s_x;
        neg_rng = -rng;
        neg     = rng[COORD_BITS];
        zero    = (rng == '0);
        mag     = neg ? neg_rng[COORD_BITS-1:0] : rng[COORD_BITS-1:0];
        mag_x   = DIV_W'(mag);
        t_x     = DIV_W'(t_val);
        t_div   = (t_val == '0) ? DIV_W'(1) : t_x;
        big     = (mag_x >= t_x);
        dividend = big ? mag_x : t_x;
        divisor  = big ? t_div : mag_x;
        q8      = quo[COORD_BITS-1:0];
        if (zero)
        begin
            wr_step = '0;
        end
        else if (big)
        begin
            wr_step = neg ? -q8 : q8;
        end
        else
        begin
            wr_step = neg ? -coord_t'(1) : coord_t'(1);
        end
    end

    rta_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pos_next[a]   = pos_reg[a];
            step_next[a]  = step_reg[a];
            hp_next[a]    = hp_reg[a];
            hc_next[a]    = hc_reg[a];
            every_next[a] = every_reg[a];
        end
        time_next = time_reg;
        done_next = done_reg;

        if (cmd.apply_mode)
        begin
            case (mode_reg)
                MODE_TICK:
                begin
                    if (time_reg != '0)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            if (every_reg[a])
                            begin
                                pos_next[a] = pos_reg[a] + step_reg[a];
                            end
                            else if (hc_reg[a] != '0)
                            begin
                                hc_next[a] = hc_reg[a] - TIME_BITS'(1);
                            end
                            else
                            begin
                                pos_next[a] = pos_reg[a] + step_reg[a];
                                hc_next[a]  = hp_reg[a];
                            end
                        end
                        done_next = 1'b0;
                        time_next = time_reg - TIME_BITS'(1);
                    end
                    else
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            pos_next[a] = rect_field(target_rect, AXIS_IDX_W'(a));
                        end
                        done_next = 1'b1;
                    end
                end
                MODE_RELOAD:
                begin
                    time_next = t_val;
                end
                MODE_STOP:
                begin
                    done_next = 1'b1;
                    time_next = '0;
                end
                default: ;
            endcase
        end

        if (cmd.axis_wr)
        begin
            pos_next[cmd.axis]   = rel ? coord_t'(0) : s_f;
            step_next[cmd.axis]  = wr_step;
            every_next[cmd.axis] = zero || big;
            hp_next[cmd.axis]    = (zero || big) ? '0 : quo[TIME_BITS-1:0];
            hc_next[cmd.axis]    = (zero || big) ? '0 : quo[TIME_BITS-1:0];
            time_next            = t_val;
            done_next            = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                pos_reg[a]  <= '0;
                step_reg[a] <= '0;
                hp_reg[a]   <= '0;
                hc_reg[a]   <= '0;
            end
            every_reg     <= '1;
            time_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                pos_reg[a]  <= pos_next[a];
                step_reg[a] <= step_next[a];
                hp_reg[a]   <= hp_next[a];
                hc_reg[a]   <= hc_next[a];
            end
            every_reg <= every_next;
            time_reg  <= time_next;
            done_reg  <= done_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            mode_reg    <= mode;
            orig_reg[0] <= original_col;
            orig_reg[1] <= original_row;
            orig_reg[2] <= original_width;
            orig_reg[3] <= original_height;
        end
        if (cmd.out_load)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                out_reg[a] <= out_coord_t'(pos_reg[a])
                    + ((rect_field(start_rect, AXIS_IDX_W'(a)) == REL_MARK)
                       ? out_coord_t'(orig_reg[a]) : out_coord_t'(0));
            end
            fin_reg <= done_reg;
        end
    end

    assign status.div_busy   = div_busy;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.is_restart = (mode_reg == MODE_RESTART);

    assign out_valid   = out_valid_reg;
    assign rect_col    = out_reg[0];
    assign rect_row    = out_reg[1];
    assign rect_width  = out_reg[2];
    assign rect_height = out_reg[3];
    assign finished    = fin_reg;

endmodule

`default_nettype wire

### rtl/core/rta_ctrl.sv
// sequencing state machine for items, restart derivation and results
`default_nettype none

module rta_ctrl import rta_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_EXEC      = 6'b000010,
        S_DIV_START = 6'b000100,
        S_DIV_WAIT  = 6'b001000,
        S_AXIS_WR   = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [AXIS_IDX_W-1:0] axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.is_restart)
                begin
                    axis_next  = '0;
                    state_next = S_DIV_START;
                end
                else
                begin
                    cmd.apply_mode = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_AXIS_WR;
                end
            end
            S_AXIS_WR:
            begin
                cmd.axis_wr = 1'b1;
                if (axis_reg == AXIS_IDX_W'(NUM_AXES - 1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    axis_next  = axis_reg + AXIS_IDX_W'(1);
                    state_next = S_DIV_START;
                end
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rect_tween_animator.sv
// top level of the rectangle tween animator
//
//  channel  | kind      | transfer                      | payload
//  ---------+-----------+-------------------------------+-------------------------------------
//  item     | sink      | valid && ready                | mode, original col/row/width/height
//  result   | source    | valid && ready                | rect col/row/width/height, finished
//  apb      | cfg slave | psel && penable && pwrite     | start_rect, target_rect, duration
//
//  tick, reload and stop go from S_EXEC to S_RESP, which loads the registered result
//  restart runs S_DIV_START, S_DIV_WAIT and S_AXIS_WR per axis on the shared W = max(TIME_BITS, 8) bit divider
//  reset clears all axis state, so ticks before a restart do not move and then snap
//  the next item is accepted while a result still waits; a stalled result holds the sequencer
`default_nettype none

module rect_tween_animator import rta_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    rta_item_if.sink          item,
    rta_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [RECT_W-1:0] start_rect;
    logic [RECT_W-1:0] target_rect;
    logic [DUR_W-1:0]  duration;
    dp_cmd_t           cmd;
    dp_status_t        status;

    rta_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start_rect  (start_rect),
        .target_rect (target_rect),
        .duration    (duration)
    );

    rta_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    rta_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mode            (item.mode),
        .original_col    (item.original_col),
        .original_row    (item.original_row),
        .original_width  (item.original_width),
        .original_height (item.original_height),
        .start_rect      (start_rect),
        .target_rect     (target_rect),
        .duration        (duration),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .rect_col        (result.rect_col),
        .rect_row        (result.rect_row),
        .rect_width      (result.rect_width),
        .rect_height     (result.rect_height),
        .finished        (result.finished)
    );

endmodule

`default_nettype wire

### rtl/core/rta_checker.sv
// port-level checks for the rectangle tween animator, bound to the top level
`default_nettype none

module rta_checker import rta_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input out_coord_t        rect_col,
    input out_coord_t        rect_row,
    input out_coord_t        rect_width,
    input out_coord_t        rect_height,
    input logic              finished,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    // one item at a time: after an accepted transaction the input is closed
    a_item_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item accepted while a previous one was in progress");

    // stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(rect_col) && $stable(rect_row)
             && $stable(rect_width) && $stable(rect_height) && $stable(finished)))
        else $error("stalled result changed");

    // duration write is visible to a read straight after it
    a_duration_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_DURATION) |=>
            (!psel || pwrite || paddr[ADDR_W-1:2] != REG_DURATION
             || prdata[DUR_W-1:0] == $past(pwdata[DUR_W-1:0])))
        else $error("duration register readback mismatch");

    // start rectangle write is visible to a read straight after it
    a_start_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_START_RECT) |=>
            (!psel || pwrite || paddr[ADDR_W-1:2] != REG_START_RECT
             || prdata[RECT_W-1:0] == $past(pwdata[RECT_W-1:0])))
        else $error("start rectangle readback mismatch");

endmodule

bind rect_tween_animator rta_checker u_rta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .rect_col     (result.rect_col),
    .rect_row     (result.rect_row),
    .rect_width   (result.rect_width),
    .rect_height  (result.rect_height),
    .finished     (result.finished),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
);

`default_nettype wire

### bench/rect_tween_animator_tb.sv
// testbench for the rectangle tween animator: table-driven and random transactions checked against a predictor

module rect_tween_animator_tb;
    import rta_pkg::*;

    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_REPORTS   = 10;
    localparam logic signed [16:0] EVERY_TICK = -17'sd1;

    typedef struct packed {
        out_coord_t col;
        out_coord_t row;
        out_coord_t width;
        out_coord_t height;
        logic       finished;
    } frame_t;

    typedef struct packed {
        logic        is_cfg;
        reg_idx_t    reg_sel;
        logic [31:0] value;
        mode_t       mode;
        logic [31:0] orig;
        logic        known;
        frame_t      want;
    } stim_row_t;

    localparam frame_t NO_FRAME = '0;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rta_item_if   item_ch ();
    rta_result_if result_ch ();

    rect_tween_animator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // register shadows and animation state of the predictor
    logic [31:0]        cfg_start;
    logic [31:0]        cfg_target;
    logic [15:0]        cfg_dur;
    coord_t             pos [4];
    coord_t             stp [4];
    logic [15:0]        hold_per [4];
    logic signed [16:0] hold_cnt [4];
    logic [15:0]        time_left;
    logic               done_flag;

    frame_t    frames_due [$];
    stim_row_t script [32];
    logic      row_known;
    frame_t    row_frame;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;
    int        items_in;
    int        frames_out;
    int        restarts;
    int        snaps;
    int        settings;
    int        quiet_cycles;

    function automatic int axis_val(input logic [31:0] r, input int a);
        coord_t c;
        c = r[a*COORD_BITS +: COORD_BITS];
        return int'(c);
    endfunction

    function automatic stim_row_t cfg_row(input reg_idx_t idx, input logic [31:0] value);
        return '{1'b1, idx, value, MODE_TICK, 32'h0, 1'b0, NO_FRAME};
    endfunction

    function automatic stim_row_t item_row(input mode_t m, input logic [31:0] orig,
                                           input logic known, input frame_t want);
        return '{1'b0, REG_START_RECT, 32'h0, m, orig, known, want};
    endfunction

    task automatic advance_rect(input mode_t m, input logic [31:0] orig, output frame_t f);
        int         t;
        int         dv;
        int         s;
        int         g;
        int         span;
        int         mag;
        int         q;
        out_coord_t o [4];
        case (m)
            MODE_TICK:
            begin
                if (time_left != 0)
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if (hold_cnt[a] == EVERY_TICK)
                            pos[a] = pos[a] + stp[a];
                        else if (hold_cnt[a] > 0)
                            hold_cnt[a] = hold_cnt[a] - 17'sd1;
                        else
                        begin
                            pos[a] = pos[a] + stp[a];
                            hold_cnt[a] = {1'b0, hold_per[a]};
                        end
                    end
                    done_flag = 1'b0;
                    time_left = time_left - 16'd1;
                end
                else
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                        pos[a] = coord_t'(axis_val(cfg_target, a));
                    done_flag = 1'b1;
                    snaps++;
                end
            end
            MODE_RESTART:
            begin
                t = int'(cfg_dur);
                dv = (t == 0) ? 1 : t;
                time_left = cfg_dur;
                done_flag = 1'b0;
                restarts++;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    s = axis_val(cfg_start, a);
                    g = axis_val(cfg_target, a);
                    span = (s == -1) ? g : g - s;
                    mag = (span < 0) ? -span : span;
                    pos[a] = coord_t'((s == -1) ? 0 : s);
                    hold_per[a] = '0;
                    if (span == 0)
                    begin
                        stp[a] = '0;
                        hold_cnt[a] = EVERY_TICK;
                    end
                    else if (mag >= t)
                    begin
                        q = mag / dv;
                        stp[a] = coord_t'((span < 0) ? -q : q);
                        hold_cnt[a] = EVERY_TICK;
                    end
                    else
                    begin
                        stp[a] = (span > 0) ? 8'sd1 : -8'sd1;
                        hold_per[a] = 16'(t / mag);
                        hold_cnt[a] = {1'b0, hold_per[a]};
                    end
                end
            end
            MODE_RELOAD:
                time_left = cfg_dur;
            default:
            begin
                done_flag = 1'b1;
                time_left = '0;
            end
        endcase
        for (int a = 0; a < NUM_AXES; a++)
            o[a] = out_coord_t'(int'(pos[a])
                                + ((axis_val(cfg_start, a) == -1) ? axis_val(orig, a) : 0));
        f = '{o[0], o[1], o[2], o[3], done_flag};
    endtask

    task automatic report_mismatch(input string what, input frame_t want, input frame_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s: expected %0d %0d %0d %0d fin %0b, got %0d %0d %0d %0d fin %0b", what,
                     want.col, want.row, want.width, want.height, want.finished,
                     got.col, got.row, got.width, got.height, got.finished);
    endtask

    // scoreboard and watchdog counter
    always @(posedge clk)
    begin
        frame_t want;
        frame_t got;
        if (result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.rect_col, result_ch.rect_row, result_ch.rect_width,
                    result_ch.rect_height, result_ch.finished};
            frames_out++;
            if (frames_due.size() == 0)
                report_mismatch("unexpected frame", NO_FRAME, got);
            else
            begin
                want = frames_due.pop_front();
                if (got.col != want.col || got.row != want.row || got.width != want.width
                    || got.height != want.height || got.finished != want.finished)
                    report_mismatch("frame mismatch", want, got);
            end
        end
        if (item_ch.valid && item_ch.ready)
        begin
            advance_rect(mode_t'(item_ch.mode),
                         {item_ch.original_height, item_ch.original_width,
                          item_ch.original_row, item_ch.original_col}, want);
            if (row_known)
                want = row_frame;
            frames_due.push_back(want);
            items_in++;
        end
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("rect_tween_animator_tb: errors");
        $finish;
    end

    // result receiver
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic settle();
        item_ch.valid = 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_START_RECT:  cfg_start = value;
            REG_TARGET_RECT: cfg_target = value;
            default:         cfg_dur = value[15:0];
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic offer_item(input mode_t m, input logic [31:0] orig,
                              input logic known, input frame_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.mode = m;
        item_ch.original_col = orig[7:0];
        item_ch.original_row = orig[15:8];
        item_ch.original_width = orig[23:16];
        item_ch.original_height = orig[31:24];
        row_known = known;
        row_frame = want;
        item_ch.valid = 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pick_settings();
        logic [31:0] st;
        logic [31:0] tg;
        int          roll;
        settle();
        for (int a = 0; a < NUM_AXES; a++)
        begin
            roll = $urandom_range(99);
            st[a*8 +: 8] = (roll < 25) ? 8'hFF : (roll < 35) ? 8'h80 : (roll < 45) ? 8'h7F
                                                                           : 8'($urandom());
            roll = $urandom_range(99);
            tg[a*8 +: 8] = (roll < 10) ? 8'h80 : (roll < 20) ? 8'h7F : (roll < 30) ? 8'h00
                                                                           : 8'($urandom());
        end
        write_reg(REG_START_RECT, st);
        write_reg(REG_TARGET_RECT, tg);
        roll = $urandom_range(9);
        write_reg(REG_DURATION, (roll == 0) ? 32'd65535 :
                                (roll == 1) ? 32'($urandom_range(2000, 100)) :
                                              32'($urandom_range(40, 1)));
        settings++;
    endtask

    task automatic run_segment(input int count);
        int    left;
        int    k;
        int    roll;
        mode_t m;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(99) < 8)
            begin
                offer_item(mode_t'($urandom_range(3)), $urandom(), 1'b0, NO_FRAME);
                left--;
            end
            else
            begin
                offer_item(MODE_RESTART, $urandom(), 1'b0, NO_FRAME);
                left--;
                k = $urandom_range((cfg_dur > 60) ? 60 : int'(cfg_dur) + 3);
                if (k > left)
                    k = left;
                for (int i = 0; i < k; i++)
                begin
                    roll = $urandom_range(99);
                    m = (roll < 5) ? MODE_RELOAD : (roll < 8) ? MODE_STOP : MODE_TICK;
                    offer_item(m, $urandom(), 1'b0, NO_FRAME);
                end
                left -= k;
            end
            if ($urandom_range(99) < 3)
                settle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_TICK;
        item_ch.original_col = '0;
        item_ch.original_row = '0;
        item_ch.original_width = '0;
        item_ch.original_height = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        row_known = 1'b0;
        row_frame = NO_FRAME;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        items_in = 0;
        frames_out = 0;
        restarts = 0;
        snaps = 0;
        settings = 1;
        cfg_start = '0;
        cfg_target = '0;
        cfg_dur = 16'd1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pos[a] = '0;
            stp[a] = '0;
            hold_per[a] = '0;
            hold_cnt[a] = EVERY_TICK;
        end
        time_left = '0;
        done_flag = 1'b0;

        script = '{
            // ticks straight after reset snap to the zero target
            item_row(MODE_TICK, 32'h0, 1'b1, '{9'sd0, 9'sd0, 9'sd0, 9'sd0, 1'b1}),
            item_row(MODE_TICK, 32'h7F80_FF01, 1'b1, '{9'sd0, 9'sd0, 9'sd0, 9'sd0, 1'b1}),
            // full-range spans, two relative axes, wrapping step
            cfg_row(REG_START_RECT, 32'hFFFF_7F80),
            cfg_row(REG_TARGET_RECT, 32'h807F_807F),
            cfg_row(REG_DURATION, 32'd1),
            item_row(MODE_RESTART, 32'h7F80_0000, 1'b1,
                     '{-9'sd128, 9'sd127, -9'sd128, 9'sd127, 1'b0}),
            item_row(MODE_TICK, 32'h7F80_0000, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h7F80_0000, 1'b0, NO_FRAME),
            // reload without restart runs past the target
            item_row(MODE_RELOAD, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0102_0304, 1'b0, NO_FRAME),
            item_row(MODE_STOP, 32'h0, 1'b0, NO_FRAME),
            // zero duration
            cfg_row(REG_DURATION, 32'd0),
            item_row(MODE_RESTART, 32'hFFFF_FFFF, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h8080_8080, 1'b0, NO_FRAME),
            // zero range, longest duration
            cfg_row(REG_START_RECT, 32'h0),
            cfg_row(REG_TARGET_RECT, 32'h0),
            cfg_row(REG_DURATION, 32'd65535),
            item_row(MODE_RESTART, 32'h0, 1'b1, '{9'sd0, 9'sd0, 9'sd0, 9'sd0, 1'b0}),
            item_row(MODE_TICK, 32'h0, 1'b1, '{9'sd0, 9'sd0, 9'sd0, 9'sd0, 1'b0}),
            item_row(MODE_TICK, 32'h5A5A_A5A5, 1'b0, NO_FRAME),
            // short spans that move once per hold period
            cfg_row(REG_TARGET_RECT, 32'hFF04_0201),
            cfg_row(REG_DURATION, 32'd5),
            item_row(MODE_RESTART, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_STOP, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_RELOAD, 32'h0, 1'b0, NO_FRAME),
            item_row(MODE_TICK, 32'h0, 1'b0, NO_FRAME)
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                write_reg(script[i].reg_sel, script[i].value);
                settings++;
            end
            else
                offer_item(script[i].mode, script[i].orig, script[i].known, script[i].want);
        end

        for (int p = 0; p < 4; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct = 12;
                    recv_stall_pct = 12;
                end
            endcase
            for (int s = 0; s < 2; s++)
            begin
                pick_settings();
                run_segment(81);
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d frames over %0d register settings",
                 items_in, frames_out, settings);
        $display("with %0d restarts, %0d snaps to target and %0d mismatches",
                 restarts, snaps, error_count);
        if (error_count == 0 && frames_due.size() == 0)
            $display("rect_tween_animator_tb: clean");
        else
        begin
            if (frames_due.size() != 0)
                $display("%0d expected frames never arrived", frames_due.size());
            $display("rect_tween_animator_tb: errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/rta_pkg.sv
rtl/core/rta_item_if.sv
rtl/core/rta_result_if.sv
rtl/core/rta_regs.sv
rtl/core/rta_div.sv
rtl/core/rta_datapath.sv
rtl/core/rta_ctrl.sv
rtl/core/rect_tween_animator.sv
rtl/core/rta_checker.sv
bench/rect_tween_animator_tb.sv
